FILE: rtl/lab_pkg.sv
// Shared types and fixed field widths for the look-at camera basis block.
// No dependencies; lab_in_if, lab_out_if and look_at_camera_basis_top import this package.
`default_nettype none

package lab_pkg;

    localparam int IN_W  = 32;   // input coordinate width
    localparam int OUT_W = 18;   // output component width
    localparam int D_W   = 33;   // eye - target difference
    localparam int HL_W  = 16;   // upper limb of |d| for squaring
    localparam int LL_W  = 17;   // lower limb of |d| for squaring
    localparam int SQ_W  = 65;   // d_i squared
    localparam int S_W   = 66;   // sums of squares
    localparam int LIMB  = 22;   // limb width for the wide products
    localparam int NLIMB = 3;    // limbs per 66-bit operand
    localparam int PP_W  = 2 * LIMB;
    localparam int ROW_W = 4 * LIMB;
    localparam int P_W   = 2 * S_W;  // wide products

    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic pos_x;
        logic degen;
    } lab_flag_t;

endpackage

`default_nettype wire

FILE: rtl/lab_in_if.sv
// Input channel: eye and target positions with valid/ready handshake.
// Depends on lab_pkg.
`default_nettype none

interface lab_in_if import lab_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] eye_x;
    logic signed [IN_W-1:0] eye_y;
    logic signed [IN_W-1:0] eye_z;
    logic signed [IN_W-1:0] target_x;
    logic signed [IN_W-1:0] target_y;
    logic signed [IN_W-1:0] target_z;
    logic                   target_present;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, target_present,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z, target_present,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/lab_out_if.sv
// Output channel: nine basis components and the degenerate flag.
// Depends on lab_pkg.
`default_nettype none

interface lab_out_if import lab_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] up_out_x;
    logic signed [OUT_W-1:0] up_out_y;
    logic signed [OUT_W-1:0] up_out_z;
    logic signed [OUT_W-1:0] back_x;
    logic signed [OUT_W-1:0] back_y;
    logic signed [OUT_W-1:0] back_z;
    logic                    degenerate;

    modport source (
        output valid, right_x, right_y, right_z, up_out_x, up_out_y, up_out_z,
               back_x, back_y, back_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, right_x, right_y, right_z, up_out_x, up_out_y, up_out_z,
               back_x, back_y, back_z, degenerate,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/look_at_camera_basis_top.sv
// Look-at camera basis: front end (difference, squares, wide products) and
// eight root-ratio units. Depends on lab_pkg, lab_in_if, lab_out_if, lab_rootdiv.
//
// Usage:
//   cam   (sink):   eye and target position, 16 fraction bits; target_present
//                   low means the target is the origin.
//   basis (source): right, up_out and back axes, FRAC_BITS fraction bits,
//                   truncated toward zero, plus a degenerate flag. When the eye
//                   equals the target or the view is parallel to the y axis,
//                   degenerate is high and all nine components are zero.
//   One transaction on basis for each transaction on cam, in order.
//   The pipeline is eight front stages, 2*FRAC_BITS+1 divider stages,
//   FRAC_BITS+1 root stages and the output register. Throughput is one
//   transaction per cycle while the receiver does not stall.
//   The whole pipeline advances when the output register is empty or taken;
//   while the receiver stalls the pipeline holds and cam.ready is low.
//   Reset clears all valid bits; no transaction is in flight afterwards.
`default_nettype none

module look_at_camera_basis_top import lab_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lab_in_if.sink    cam,
    lab_out_if.source basis
);

    localparam int RTW = FRAC_BITS + 1;
    localparam int LAT = 3 * FRAC_BITS + 2;
    localparam int NF  = 8 + LAT;
    localparam int MW  = (RTW > OUT_W) ? RTW : OUT_W;

    function automatic logic [OUT_W-1:0] emit(input logic [RTW-1:0] mag, input logic neg);
        logic [MW-1:0] m;
        logic [MW-1:0] v;
        m = MW'(mag);
        v = neg ? (-m) : m;
        return v[OUT_W-1:0];
    endfunction

    logic en;
    assign en = !basis.valid || basis.ready;
    assign cam.ready = en;

    lab_flag_t flg_reg [0:NF-1];

    logic signed [D_W-1:0] d_reg   [0:2];
    logic        [D_W-1:0] a_reg   [0:2];
    logic [2*HL_W-1:0]     hh_reg  [0:2];
    logic [HL_W+LL_W-1:0]  hl_reg  [0:2];
    logic [2*LL_W-1:0]     ll_reg  [0:2];
    logic [SQ_W-1:0]       sq4_reg [0:2];
    logic [SQ_W-1:0]       sq5_reg [0:2];
    logic [SQ_W-1:0]       sq6_reg [0:2];
    logic [SQ_W-1:0]       sq7_reg [0:2];
    logic [SQ_W-1:0]       sq8_reg [0:2];
    logic [S_W-1:0]        h2_5_reg, h2_6_reg, h2_7_reg, h2_8_reg;
    logic [S_W-1:0]        s2_5_reg, s2_6_reg, s2_7_reg, s2_8_reg;
    logic [S_W-1:0]        opa [0:2];
    logic [S_W-1:0]        opb [0:2];
    logic [PP_W-1:0]       pp_reg   [0:2][0:NLIMB*NLIMB-1];
    logic [ROW_W-1:0]      row_reg  [0:2][0:NLIMB-1];
    logic [P_W-1:0]        prod_reg [0:2];

    logic signed [D_W-1:0] eye_d [0:2];
    logic signed [D_W-1:0] tgt_d [0:2];

    assign eye_d[0] = D_W'(cam.eye_x);
    assign eye_d[1] = D_W'(cam.eye_y);
    assign eye_d[2] = D_W'(cam.eye_z);
    assign tgt_d[0] = cam.target_present ? D_W'(cam.target_x) : '0;
    assign tgt_d[1] = cam.target_present ? D_W'(cam.target_y) : '0;
    assign tgt_d[2] = cam.target_present ? D_W'(cam.target_z) : '0;

    // valid and sign flags ride alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NF; k++)
            begin
                flg_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            flg_reg[0]       <= '{valid: cam.valid, default: 1'b0};
            flg_reg[1].valid <= flg_reg[0].valid;
            flg_reg[1].neg_x <= d_reg[0][D_W-1];
            flg_reg[1].neg_y <= d_reg[1][D_W-1];
            flg_reg[1].neg_z <= d_reg[2][D_W-1];
            flg_reg[1].pos_x <= !d_reg[0][D_W-1] && (d_reg[0] != '0);
            flg_reg[1].degen <= (d_reg[0] == '0) && (d_reg[2] == '0);
            for (int k = 2; k < NF; k++)
            begin
                flg_reg[k] <= flg_reg[k-1];
            end
        end
    end

    assign opa[0] = s2_5_reg;
    assign opb[0] = h2_5_reg;
    assign opa[1] = S_W'(sq5_reg[1]);
    assign opb[1] = S_W'(sq5_reg[0]);
    assign opa[2] = S_W'(sq5_reg[1]);
    assign opb[2] = S_W'(sq5_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]   <= eye_d[i] - tgt_d[i];
                a_reg[i]   <= d_reg[i][D_W-1] ? D_W'(-d_reg[i]) : D_W'(d_reg[i]);
                hh_reg[i]  <= a_reg[i][D_W-1:LL_W] * a_reg[i][D_W-1:LL_W];
                hl_reg[i]  <= a_reg[i][D_W-1:LL_W] * a_reg[i][LL_W-1:0];
                ll_reg[i]  <= a_reg[i][LL_W-1:0] * a_reg[i][LL_W-1:0];
                sq4_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * LL_W))
                            + (SQ_W'(hl_reg[i]) << (LL_W + 1))
                            + SQ_W'(ll_reg[i]);
                sq5_reg[i] <= sq4_reg[i];
                sq6_reg[i] <= sq5_reg[i];
                sq7_reg[i] <= sq6_reg[i];
                sq8_reg[i] <= sq7_reg[i];
            end
            h2_5_reg <= S_W'(sq4_reg[0]) + S_W'(sq4_reg[2]);
            s2_5_reg <= S_W'(sq4_reg[0]) + S_W'(sq4_reg[1]) + S_W'(sq4_reg[2]);
            h2_6_reg <= h2_5_reg;
            s2_6_reg <= s2_5_reg;
            h2_7_reg <= h2_6_reg;
            s2_7_reg <= s2_6_reg;
            h2_8_reg <= h2_7_reg;
            s2_8_reg <= s2_7_reg;
            for (int m = 0; m < 3; m++)
            begin
                for (int i = 0; i < NLIMB; i++)
                begin
                    for (int j = 0; j < NLIMB; j++)
                    begin
                        pp_reg[m][i*NLIMB+j] <= opa[m][LIMB*i +: LIMB] * opb[m][LIMB*j +: LIMB];
                    end
                    row_reg[m][i] <= ROW_W'(pp_reg[m][i*NLIMB])
                                   + (ROW_W'(pp_reg[m][i*NLIMB+1]) << LIMB)
                                   + (ROW_W'(pp_reg[m][i*NLIMB+2]) << (2 * LIMB));
                end
                prod_reg[m] <= P_W'(row_reg[m][0])
                             + (P_W'(row_reg[m][1]) << LIMB)
                             + (P_W'(row_reg[m][2]) << (2 * LIMB));
            end
        end
    end

    logic [RTW-1:0] q_rx, q_rz, q_ux, q_uy, q_uz, q_bx, q_by, q_bz;

    lab_rootdiv #(.DW(S_W), .FRAC(FRAC_BITS)) u_rx (
        .clk(clk), .en(en), .num(S_W'(sq8_reg[2])), .den(h2_8_reg), .q(q_rx));
    lab_rootdiv #(.DW(S_W), .FRAC(FRAC_BITS)) u_rz (
        .clk(clk), .en(en), .num(S_W'(sq8_reg[0])), .den(h2_8_reg), .q(q_rz));
    lab_rootdiv #(.DW(P_W), .FRAC(FRAC_BITS)) u_ux (
        .clk(clk), .en(en), .num(prod_reg[1]), .den(prod_reg[0]), .q(q_ux));
    lab_rootdiv #(.DW(S_W), .FRAC(FRAC_BITS)) u_uy (
        .clk(clk), .en(en), .num(h2_8_reg), .den(s2_8_reg), .q(q_uy));
    lab_rootdiv #(.DW(P_W), .FRAC(FRAC_BITS)) u_uz (
        .clk(clk), .en(en), .num(prod_reg[2]), .den(prod_reg[0]), .q(q_uz));
    lab_rootdiv #(.DW(S_W), .FRAC(FRAC_BITS)) u_bx (
        .clk(clk), .en(en), .num(S_W'(sq8_reg[0])), .den(s2_8_reg), .q(q_bx));
    lab_rootdiv #(.DW(S_W), .FRAC(FRAC_BITS)) u_by (
        .clk(clk), .en(en), .num(S_W'(sq8_reg[1])), .den(s2_8_reg), .q(q_by));
    lab_rootdiv #(.DW(S_W), .FRAC(FRAC_BITS)) u_bz (
        .clk(clk), .en(en), .num(S_W'(sq8_reg[2])), .den(s2_8_reg), .q(q_bz));

    lab_flag_t fo;
    assign fo = flg_reg[NF-1];

    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fo.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            basis.degenerate <= fo.degen;
            if (fo.degen)
            begin
                basis.right_x  <= '0;
                basis.right_y  <= '0;
                basis.right_z  <= '0;
                basis.up_out_x <= '0;
                basis.up_out_y <= '0;
                basis.up_out_z <= '0;
                basis.back_x   <= '0;
                basis.back_y   <= '0;
                basis.back_z   <= '0;
            end
            else
            begin
                basis.right_x  <= emit(q_rx, fo.neg_z);
                basis.right_y  <= '0;
                basis.right_z  <= emit(q_rz, fo.pos_x);
                basis.up_out_x <= emit(q_ux, fo.neg_y == fo.neg_x);
                basis.up_out_y <= emit(q_uy, 1'b0);
                basis.up_out_z <= emit(q_uz, fo.neg_y == fo.neg_z);
                basis.back_x   <= emit(q_bx, fo.neg_x);
                basis.back_y   <= emit(q_by, fo.neg_y);
                basis.back_z   <= emit(q_bz, fo.neg_z);
            end
        end
    end

    assign basis.valid = out_valid_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        basis.valid && basis.degenerate |->
            basis.right_x == '0 && basis.right_z == '0 && basis.up_out_x == '0 &&
            basis.up_out_y == '0 && basis.up_out_z == '0 && basis.back_x == '0 &&
            basis.back_y == '0 && basis.back_z == '0)
        else $error("degenerate transaction with nonzero basis");

    a_right_y: assert property (@(posedge clk) disable iff (!rst_n)
        basis.valid && !basis.degenerate |-> basis.right_y == '0)
        else $error("right_y nonzero");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cam.valid && cam.ready |=> flg_reg[0].valid)
        else $error("accepted transaction lost at pipeline entry");

endmodule

`default_nettype wire

FILE: rtl/lab_rootdiv.sv
// Pipelined floor(sqrt(floor(num * 2^(2*FRAC) / den))) for num <= den.
// Restoring divider, one quotient bit per stage, then a bitwise square root.
`default_nettype none

module lab_rootdiv #(
    parameter int DW   = 66,
    parameter int FRAC = 16
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [FRAC:0] q
);

    localparam int QW    = 2 * FRAC + 1;
    localparam int RW    = DW + 1;
    localparam int STEPS = 2 * FRAC;
    localparam int RTW   = FRAC + 1;

    logic [RW-1:0]  rem_reg  [0:STEPS-1];
    logic [DW-1:0]  den_reg  [0:STEPS-1];
    logic [QW-1:0]  quo_reg  [0:STEPS];
    logic [QW-1:0]  rad_reg  [0:FRAC-1];
    logic [RTW-1:0] root_reg [0:FRAC];

    // integer bit of the quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (num >= den)
            begin
                rem_reg[0] <= RW'(num - den);
                quo_reg[0] <= QW'(1);
            end
            else
            begin
                rem_reg[0] <= RW'(num);
                quo_reg[0] <= '0;
            end
            den_reg[0] <= den;
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_div
        logic [RW-1:0] sh;
        logic          ge;
        assign sh = {rem_reg[k-1][RW-2:0], 1'b0};
        assign ge = (sh >= {1'b0, den_reg[k-1]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge};
            end
        end
        if (k < STEPS)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (sh - {1'b0, den_reg[k-1]}) : sh;
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    for (genvar j = 0; j <= FRAC; j++)
    begin : g_sqrt
        logic [QW-1:0]    rad_in;
        logic [RTW-1:0]   q_in;
        logic [RTW-1:0]   t;
        logic [2*RTW-1:0] t_sq;
        if (j == 0)
        begin : g_first
            assign rad_in = quo_reg[STEPS];
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rad_in = rad_reg[j-1];
            assign q_in   = root_reg[j-1];
        end
        assign t    = q_in | (RTW'(1) << (FRAC - j));
        assign t_sq = t * t;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[j] <= (t_sq <= {1'b0, rad_in}) ? t : q_in;
            end
        end
        if (j < FRAC)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[j] <= rad_in;
                end
            end
        end
    end

    assign q = root_reg[FRAC];

endmodule

`default_nettype wire
